// ----- rtl/cgfw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgfw_pkg: shared definitions of the face walker
// widths, limits, status codes and the structs that run between the
// sequencer, the slot search unit and the neighbor table
// ----------------------------------------------------------------------------
package cgfw_pkg;

    // node ids and table entries
    localparam int NODE_W        = 10;
    localparam int ENTRY_W       = 12;
    // table depth, a power of two so that wrapping is a plain truncation
    localparam int TABLE_ENTRIES = 4096;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

    // face length limit, capped by the number of results a walk may give
    localparam int MAX_FACE      = 6;
    localparam int RESULT_CAP    = 7;
    localparam int FACE_LIMIT    = (MAX_FACE < RESULT_CAP) ? MAX_FACE : RESULT_CAP;
    localparam int POS_W         = 3;
    localparam int BUF_IDX_W     = $clog2(FACE_LIMIT);

    // three clockwise slots per node
    localparam int NUM_SLOTS     = 3;
    localparam int SLOT_W        = $clog2(NUM_SLOTS);

    // request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_WALK = 1'b1;

    // walk status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LONG    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // one face step: find src in the list of dst
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } search_req_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [NODE_W-1:0] next_node;
    } search_rsp_t;

    // table ports
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_port_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [NODE_W-1:0] data;
    } wr_port_t;

endpackage
`default_nettype wire

// ----- rtl/cgfw_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgfw_table: neighbor table
// single write port, single registered read port, no reset on the contents
// ----------------------------------------------------------------------------
module cgfw_table (
    input  wire                          clk,
    input  cgfw_pkg::wr_port_t           wr,
    input  cgfw_pkg::rd_port_t           rd,
    output logic [cgfw_pkg::NODE_W-1:0]  rd_data
);

    logic [cgfw_pkg::NODE_W-1:0] mem [cgfw_pkg::TABLE_ENTRIES];
    logic [cgfw_pkg::NODE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- rtl/cgfw_slot_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgfw_slot_search: one face step
// reads the three slots of dst over the table port, finds src and returns
// the neighbor two slots on (lowest matching slot wins)
// ----------------------------------------------------------------------------
module cgfw_slot_search (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [cgfw_pkg::ADDR_W-1:0]   graph_base,
    input  cgfw_pkg::search_req_t        req,
    output cgfw_pkg::search_rsp_t        rsp,
    output cgfw_pkg::rd_port_t           rd,
    input  wire [cgfw_pkg::NODE_W-1:0]   rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_READ,
        S_FINISH,
        S_RESOLVE
    } state_t;

    state_t                        state_reg;
    logic [cgfw_pkg::NODE_W-1:0]   src_reg;
    logic [cgfw_pkg::NODE_W-1:0]   dst_reg;
    logic [cgfw_pkg::ADDR_W-1:0]   row_reg;
    logic [cgfw_pkg::SLOT_W-1:0]   slot_reg;
    logic                          pend_reg;
    logic [cgfw_pkg::SLOT_W-1:0]   pend_slot_reg;
    logic [cgfw_pkg::NODE_W-1:0]   val_reg [cgfw_pkg::NUM_SLOTS];

    logic [cgfw_pkg::ADDR_W-1:0]   dst_ext;
    logic [cgfw_pkg::ADDR_W-1:0]   row_next;
    logic                          found;
    logic [cgfw_pkg::NODE_W-1:0]   next_node;

    // row start: base + 3 * dst, wrapping at the table depth
    assign dst_ext  = cgfw_pkg::ADDR_W'(dst_reg);
    assign row_next = graph_base + dst_ext + (dst_ext << 1);

    // shared address adder for the slot reads
    assign rd.en   = (state_reg == S_READ);
    assign rd.addr = row_reg + cgfw_pkg::ADDR_W'(slot_reg);

    // slot match, lowest slot has priority; successor is slot minus one
    always_comb
    begin
        found     = 1'b0;
        next_node = '0;
        for (int s = cgfw_pkg::NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (val_reg[s] == src_reg)
            begin
                found     = 1'b1;
                next_node = (s == 0) ? val_reg[cgfw_pkg::NUM_SLOTS - 1] : val_reg[s - 1];
            end
        end
    end

    assign rsp.done      = (state_reg == S_RESOLVE);
    assign rsp.found     = found;
    assign rsp.next_node = next_node;

    // sequencer and slot capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            slot_reg      <= '0;
            pend_slot_reg <= '0;
        end
        else
        begin
            pend_reg      <= (state_reg == S_READ);
            pend_slot_reg <= slot_reg;
            if (pend_reg)
            begin
                val_reg[pend_slot_reg] <= rd_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        src_reg   <= req.src;
                        dst_reg   <= req.dst;
                        state_reg <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    row_reg   <= row_next;
                    slot_reg  <= '0;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (slot_reg == cgfw_pkg::SLOT_W'(cgfw_pkg::NUM_SLOTS - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_RESOLVE;
                end
                S_RESOLVE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a request only arrives while the unit is free
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (state_reg == S_IDLE))
        else $error("search request while busy");

    // the last slot read is captured before the result is resolved
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> (pend_reg && pend_slot_reg ==
            cgfw_pkg::SLOT_W'(cgfw_pkg::NUM_SLOTS - 1)))
        else $error("last slot not pending at finish");

    // table port is idle outside the read phase
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !rd.en)
        else $error("table read during resolve");

endmodule
`default_nettype wire

// ----- rtl/cgfw_walker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgfw_walker: walk sequencer
// takes walk requests, steps around the face through the slot search unit,
// keeps the node list and the smallest-source arc, then sends the results
// ----------------------------------------------------------------------------
module cgfw_walker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          kind,
    input  wire [cgfw_pkg::NODE_W-1:0]   arc_from,
    input  wire [cgfw_pkg::NODE_W-1:0]   arc_to,
    output cgfw_pkg::search_req_t        search_req,
    input  cgfw_pkg::search_rsp_t        search_rsp,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [cgfw_pkg::NODE_W-1:0]  face_node,
    output logic [cgfw_pkg::POS_W-1:0]   position,
    output logic                         last,
    output logic [cgfw_pkg::POS_W-1:0]   face_length,
    output logic [cgfw_pkg::NODE_W-1:0]  min_from,
    output logic [cgfw_pkg::NODE_W-1:0]  min_to,
    output logic [1:0]                   status
);

    typedef enum logic [1:0] {
        W_IDLE,
        W_CHECK,
        W_SEARCH,
        W_EMIT
    } state_t;

    state_t                        state_reg;
    logic [cgfw_pkg::NODE_W-1:0]   from_reg;
    logic [cgfw_pkg::NODE_W-1:0]   to_reg;
    logic [cgfw_pkg::NODE_W-1:0]   start_reg;
    logic [cgfw_pkg::NODE_W-1:0]   best_from_reg;
    logic [cgfw_pkg::NODE_W-1:0]   best_to_reg;
    logic [cgfw_pkg::POS_W-1:0]    count_reg;
    logic [cgfw_pkg::POS_W-1:0]    emit_idx_reg;
    cgfw_pkg::status_t             status_reg;
    logic [cgfw_pkg::NODE_W-1:0]   node_buf_reg [cgfw_pkg::FACE_LIMIT];

    logic                          walk_take;
    logic                          closed;
    logic                          at_limit;
    logic                          fin;
    logic                          ok_fin;
    logic                          out_take;

    assign in_ready  = (state_reg == W_IDLE);
    assign walk_take = in_valid && in_ready && (kind == cgfw_pkg::KIND_WALK);
    assign closed    = (to_reg == start_reg);
    assign at_limit  = (count_reg >= cgfw_pkg::POS_W'(cgfw_pkg::FACE_LIMIT));

    // step request to the search unit
    assign search_req.valid = (state_reg == W_CHECK) && !closed && !at_limit;
    assign search_req.src   = from_reg;
    assign search_req.dst   = to_reg;

    // result fields from the node list
    assign out_valid   = (state_reg == W_EMIT);
    assign out_take    = out_valid && out_ready;
    assign fin         = ((emit_idx_reg + 1'b1) == count_reg);
    assign ok_fin      = fin && (status_reg == cgfw_pkg::ST_OK);
    assign face_node   = node_buf_reg[emit_idx_reg[cgfw_pkg::BUF_IDX_W-1:0]];
    assign position    = emit_idx_reg;
    assign last        = fin;
    assign face_length = ok_fin ? count_reg : '0;
    assign min_from    = ok_fin ? best_from_reg : '0;
    assign min_to      = ok_fin ? best_to_reg : '0;
    assign status      = fin ? status_reg : cgfw_pkg::ST_OK;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= W_IDLE;
            from_reg      <= '0;
            to_reg        <= '0;
            start_reg     <= '0;
            best_from_reg <= '0;
            best_to_reg   <= '0;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            status_reg    <= cgfw_pkg::ST_OK;
        end
        else
        begin
            unique case (state_reg)
                W_IDLE:
                begin
                    if (walk_take)
                    begin
                        from_reg        <= arc_from;
                        to_reg          <= arc_to;
                        start_reg       <= arc_from;
                        best_from_reg   <= arc_from;
                        best_to_reg     <= arc_to;
                        node_buf_reg[0] <= arc_from;
                        count_reg       <= cgfw_pkg::POS_W'(1);
                        status_reg      <= cgfw_pkg::ST_OK;
                        state_reg       <= W_CHECK;
                    end
                end
                W_CHECK:
                begin
                    if (closed)
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= W_EMIT;
                    end
                    else if (at_limit)
                    begin
                        status_reg   <= cgfw_pkg::ST_LONG;
                        emit_idx_reg <= '0;
                        state_reg    <= W_EMIT;
                    end
                    else
                    begin
                        state_reg <= W_SEARCH;
                    end
                end
                W_SEARCH:
                begin
                    if (search_rsp.done)
                    begin
                        if (search_rsp.found)
                        begin
                            node_buf_reg[count_reg[cgfw_pkg::BUF_IDX_W-1:0]] <= to_reg;
                            count_reg <= count_reg + 1'b1;
                            from_reg  <= to_reg;
                            to_reg    <= search_rsp.next_node;
                            if (to_reg < best_from_reg)
                            begin
                                best_from_reg <= to_reg;
                                best_to_reg   <= search_rsp.next_node;
                            end
                            state_reg <= W_CHECK;
                        end
                        else
                        begin
                            status_reg   <= cgfw_pkg::ST_MISSING;
                            emit_idx_reg <= '0;
                            state_reg    <= W_EMIT;
                        end
                    end
                end
                W_EMIT:
                begin
                    if (out_take)
                    begin
                        if (fin)
                        begin
                            state_reg <= W_IDLE;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    // no new request is taken while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while results pending");

    // a good final result reports the node count it ends on
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && status == cgfw_pkg::ST_OK) |->
            (face_length == position + 1'b1))
        else $error("face length does not match final position");

    // only the final result carries a nonzero status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == cgfw_pkg::ST_OK && face_length == '0))
        else $error("status or length on a non-final result");

    // the node count never passes the face limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cgfw_pkg::POS_W'(cgfw_pkg::FACE_LIMIT))
        else $error("node count beyond face limit");

endmodule
`default_nettype wire

// ----- rtl/cubic_graph_face_walker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_graph_face_walker: face tracing over a cubic planar neighbor table
// loads table entries and walks the face of a given arc, one node per result
// ----------------------------------------------------------------------------
// A load request writes one table entry and gives no result. A walk request
// holds the input side until its last result is taken. Each face step tests
// for closure, forms the row address base + 3*node, reads the node's three
// slots through the single table read port, lets the last read land and then
// resolves the slot match. Results of a walk come out one per cycle while
// out_ready is high, the last one carrying the status and, on status OK, the
// face length and the arc with the smallest source. graph_base may only be
// written while no walk is in flight. The table has no reset; walks must only
// touch written entries.
// ----------------------------------------------------------------------------
module cubic_graph_face_walker (
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration
    input  wire                          cfg_we,
    input  wire [cgfw_pkg::ENTRY_W-1:0]  cfg_data,
    // request channel
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          kind,
    input  wire [cgfw_pkg::ENTRY_W-1:0]  entry_addr,
    input  wire [cgfw_pkg::NODE_W-1:0]   entry_node,
    input  wire [cgfw_pkg::NODE_W-1:0]   arc_from,
    input  wire [cgfw_pkg::NODE_W-1:0]   arc_to,
    // result channel
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [cgfw_pkg::NODE_W-1:0]  face_node,
    output logic [cgfw_pkg::POS_W-1:0]   position,
    output logic                         last,
    output logic [cgfw_pkg::POS_W-1:0]   face_length,
    output logic [cgfw_pkg::NODE_W-1:0]  min_from,
    output logic [cgfw_pkg::NODE_W-1:0]  min_to,
    output logic [1:0]                   status
);

    logic [cgfw_pkg::ENTRY_W-1:0]  graph_base_reg;
    cgfw_pkg::wr_port_t            tbl_wr;
    cgfw_pkg::rd_port_t            tbl_rd;
    logic [cgfw_pkg::NODE_W-1:0]   tbl_rd_data;
    cgfw_pkg::search_req_t         search_req;
    cgfw_pkg::search_rsp_t         search_rsp;
    logic                          addr_in_range;

    // graph base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            graph_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            graph_base_reg <= cfg_data;
        end
    end

    // load requests write the table directly, entries past the end are dropped
    assign addr_in_range = ({1'b0, entry_addr} <
                            (cgfw_pkg::ENTRY_W + 1)'(cgfw_pkg::TABLE_ENTRIES));
    assign tbl_wr.en     = in_valid && in_ready && (kind == cgfw_pkg::KIND_LOAD) &&
                           addr_in_range;
    assign tbl_wr.addr   = entry_addr[cgfw_pkg::ADDR_W-1:0];
    assign tbl_wr.data   = entry_node;

    cgfw_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_rd_data)
    );

    cgfw_slot_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .graph_base (graph_base_reg[cgfw_pkg::ADDR_W-1:0]),
        .req        (search_req),
        .rsp        (search_rsp),
        .rd         (tbl_rd),
        .rd_data    (tbl_rd_data)
    );

    cgfw_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .arc_from    (arc_from),
        .arc_to      (arc_to),
        .search_req  (search_req),
        .search_rsp  (search_rsp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .face_node   (face_node),
        .position    (position),
        .last        (last),
        .face_length (face_length),
        .min_from    (min_from),
        .min_to      (min_to),
        .status      (status)
    );

endmodule
`default_nettype wire

// ----- sim/face_walk_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_walk_checker: result predictor and comparator for the face walker
// keeps its own copy of the neighbor table and graph base from the observed
// configuration writes and load requests, traces each walk request ahead of
// the block and compares every accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module face_walk_checker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [cgfw_pkg::ENTRY_W-1:0]  cfg_data,
    input  wire                          in_valid,
    input  wire                          in_ready,
    input  wire                          kind,
    input  wire [cgfw_pkg::ENTRY_W-1:0]  entry_addr,
    input  wire [cgfw_pkg::NODE_W-1:0]   entry_node,
    input  wire [cgfw_pkg::NODE_W-1:0]   arc_from,
    input  wire [cgfw_pkg::NODE_W-1:0]   arc_to,
    input  wire                          out_valid,
    input  wire                          out_ready,
    input  wire [cgfw_pkg::NODE_W-1:0]   face_node,
    input  wire [cgfw_pkg::POS_W-1:0]    position,
    input  wire                          last,
    input  wire [cgfw_pkg::POS_W-1:0]    face_length,
    input  wire [cgfw_pkg::NODE_W-1:0]   min_from,
    input  wire [cgfw_pkg::NODE_W-1:0]   min_to,
    input  wire [1:0]                    status,
    output int                           fail_count,
    output int                           awaited
);
    import cgfw_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  pos;
        logic              fin;
        logic [POS_W-1:0]  len;
        logic [NODE_W-1:0] low_from;
        logic [NODE_W-1:0] low_to;
        logic [1:0]        code;
    } face_result_t;

    logic [NODE_W-1:0]  adjacency [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] graph_base;
    face_result_t       traced_nodes [$];

    // neighbor held in one slot of a node, relative to the current graph base
    function automatic logic [NODE_W-1:0] slot_node(input logic [NODE_W-1:0] nd, input int s);
        int unsigned at;
        at = (int'(graph_base) + 3 * int'(nd) + s) % TABLE_ENTRIES;
        return adjacency[at[ENTRY_W-1:0]];
    endfunction

    // trace the face of arc (src, dst) and queue the results it gives
    task automatic trace_face(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
        logic [NODE_W-1:0] path [RESULT_CAP];
        logic [NODE_W-1:0] cur_from;
        logic [NODE_W-1:0] cur_to;
        logic [NODE_W-1:0] low_from;
        logic [NODE_W-1:0] low_to;
        logic [NODE_W-1:0] onward;
        status_t           code;
        face_result_t      r;
        bit                walking;
        bit                hit;
        int                count;
        int                j;
        int                k;
        cur_from = src;
        cur_to   = dst;
        low_from = src;
        low_to   = dst;
        onward   = '0;
        path[0]  = src;
        count    = 1;
        code     = ST_OK;
        walking  = (cur_to != src);
        while (walking)
        begin
            if (count >= FACE_LIMIT)
            begin
                code    = ST_LONG;
                walking = 1'b0;
            end
            else
            begin
                // lowest slot holding the previous node wins
                hit = 1'b0;
                for (j = 0; j < NUM_SLOTS; j++)
                begin
                    if (!hit && slot_node(cur_to, j) == cur_from)
                    begin
                        hit    = 1'b1;
                        onward = slot_node(cur_to, (j + 2) % NUM_SLOTS);
                    end
                end
                if (!hit)
                begin
                    code    = ST_MISSING;
                    walking = 1'b0;
                end
                else
                begin
                    path[count] = cur_to;
                    count++;
                    cur_from = cur_to;
                    cur_to   = onward;
                    if (cur_from < low_from)
                    begin
                        low_from = cur_from;
                        low_to   = cur_to;
                    end
                    walking = (cur_to != src);
                end
            end
        end
        for (k = 0; k < count; k++)
        begin
            r.node     = path[k];
            r.pos      = k[POS_W-1:0];
            r.fin      = (k == count - 1);
            r.len      = (r.fin && code == ST_OK) ? count[POS_W-1:0] : '0;
            r.low_from = (r.fin && code == ST_OK) ? low_from : '0;
            r.low_to   = (r.fin && code == ST_OK) ? low_to : '0;
            r.code     = r.fin ? code : ST_OK;
            traced_nodes.push_back(r);
        end
    endtask

    // watch configuration, requests and results
    always @(posedge clk or negedge rst_n)
    begin : watch
        face_result_t seen;
        face_result_t want;
        if (!rst_n)
        begin
            graph_base = '0;
            traced_nodes.delete();
            fail_count <= 0;
            awaited    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                graph_base = cfg_data;
            end

            // results first, a request accepted on this edge cannot have one yet
            if (out_valid && out_ready)
            begin
                seen = {face_node, position, last, face_length, min_from, min_to, status};
                if (traced_nodes.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result: node %0d pos %0d last %0b status %0d",
                                 face_node, position, last, status);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = traced_nodes.pop_front();
                    if (seen != want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch expected: node %0d pos %0d last %0b len %0d",
                                     want.node, want.pos, want.fin, want.len,
                                     " min %0d->%0d status %0d",
                                     want.low_from, want.low_to, want.code);
                            $display("         actual:   node %0d pos %0d last %0b len %0d",
                                     seen.node, seen.pos, seen.fin, seen.len,
                                     " min %0d->%0d status %0d",
                                     seen.low_from, seen.low_to, seen.code);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end

            // accepted request: table write or face trace
            if (in_valid && in_ready)
            begin
                if (kind == KIND_LOAD)
                begin
                    adjacency[entry_addr] = entry_node;
                end
                else
                begin
                    trace_face(arc_from, arc_to);
                end
            end

            awaited <= traced_nodes.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the cubic graph face walker
// loads small hand-built graphs and prism graphs at several table offsets,
// walks their faces along with corrupted entries, self loops and stray arcs,
// with random stall bursts on both channels; a checker predicts the results
// ----------------------------------------------------------------------------
module testbench;
    import cgfw_pkg::*;

    localparam int ITEM_TARGET  = 350;
    localparam int CALM_TAIL    = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LOAD_SETTLE  = 4;
    localparam int DRAIN_CYCLES = 60;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [ENTRY_W-1:0]  cfg_data    = '0;
    logic                in_valid    = 1'b0;
    logic                kind        = KIND_LOAD;
    logic [ENTRY_W-1:0]  entry_addr  = '0;
    logic [NODE_W-1:0]   entry_node  = '0;
    logic [NODE_W-1:0]   arc_from    = '0;
    logic [NODE_W-1:0]   arc_to      = '0;
    logic                out_ready   = 1'b0;
    logic                idle_enable = 1'b1;
    wire                 in_ready;
    wire                 out_valid;
    wire [NODE_W-1:0]    face_node;
    wire [POS_W-1:0]     position;
    wire                 last;
    wire [POS_W-1:0]     face_length;
    wire [NODE_W-1:0]    min_from;
    wire [NODE_W-1:0]    min_to;
    wire [1:0]           status;
    int                  fail_count;
    int                  awaited;

    // table image used to keep walks on written entries
    logic [NODE_W-1:0]   planned_table [TABLE_ENTRIES];
    bit                  planned_written [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]  planned_base = '0;
    int                  graph_lo     = 0;
    int                  graph_span   = 8;
    int                  sent         = 0;
    int                  stall_left   = 0;
    int                  quiet_cycles = 0;

    cubic_graph_face_walker uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .entry_addr  (entry_addr),
        .entry_node  (entry_node),
        .arc_from    (arc_from),
        .arc_to      (arc_to),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .face_node   (face_node),
        .position    (position),
        .last        (last),
        .face_length (face_length),
        .min_from    (min_from),
        .min_to      (min_to),
        .status      (status)
    );

    face_walk_checker face_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .entry_addr  (entry_addr),
        .entry_node  (entry_node),
        .arc_from    (arc_from),
        .arc_to      (arc_to),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .face_node   (face_node),
        .position    (position),
        .last        (last),
        .face_length (face_length),
        .min_from    (min_from),
        .min_to      (min_to),
        .status      (status),
        .fail_count  (fail_count),
        .awaited     (awaited)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: ready, with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end
        else if (idle_enable && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 16);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // table entry of one slot of a node under the current base
    function automatic logic [ENTRY_W-1:0] slot_addr(input int nd, input int s);
        int unsigned at;
        at = (int'(planned_base) + 3 * (nd % 1024) + s) % TABLE_ENTRIES;
        return at[ENTRY_W-1:0];
    endfunction

    // first unwritten entry that a walk of arc (u, v) would read, or -1
    function automatic int unwritten_on_face(input logic [NODE_W-1:0] u,
                                             input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] cur_from;
        logic [NODE_W-1:0] cur_to;
        int                count;
        int                j;
        int                hit_slot;
        int                at;
        bit                walking;
        cur_from = u;
        cur_to   = v;
        count    = 1;
        walking  = (cur_to != u);
        while (walking)
        begin
            hit_slot = -1;
            for (j = 0; j < NUM_SLOTS; j++)
            begin
                at = int'(slot_addr(int'(cur_to), j));
                if (!planned_written[at])
                begin
                    return at;
                end
                if (hit_slot < 0 && planned_table[at] == cur_from)
                begin
                    hit_slot = j;
                end
            end
            if (count >= FACE_LIMIT || hit_slot < 0)
            begin
                walking = 1'b0;
            end
            else
            begin
                cur_from = cur_to;
                cur_to   = planned_table[slot_addr(int'(cur_from),
                                                   (hit_slot + 2) % NUM_SLOTS)];
                count++;
                walking  = (cur_to != u);
            end
        end
        return -1;
    endfunction

    // drive one request and hold it until accepted
    task automatic issue(input logic k, input logic [ENTRY_W-1:0] a,
                         input logic [NODE_W-1:0] nd, input logic [NODE_W-1:0] f,
                         input logic [NODE_W-1:0] t);
        int gap;
        gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        entry_addr <= a;
        entry_node <= nd;
        arc_from   <= f;
        arc_to     <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        if (k == KIND_LOAD)
        begin
            planned_table[a]   = nd;
            planned_written[a] = 1'b1;
        end
    endtask

    task automatic load_entry(input int a, input int nd);
        issue(KIND_LOAD, a[ENTRY_W-1:0], nd[NODE_W-1:0],
              NODE_W'($urandom_range(0, 1023)), NODE_W'($urandom_range(0, 1023)));
    endtask

    // three slots of one node, clockwise
    task automatic load_node(input int nd, input int n0, input int n1, input int n2);
        load_entry(int'(slot_addr(nd, 0)), n0);
        load_entry(int'(slot_addr(nd, 1)), n1);
        load_entry(int'(slot_addr(nd, 2)), n2);
    endtask

    // walk request, after filling any entry the walk would read unwritten
    task automatic walk_arc(input int u, input int v);
        int hole;
        hole = unwritten_on_face(u[NODE_W-1:0], v[NODE_W-1:0]);
        while (hole >= 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                load_entry(hole, $urandom_range(0, 1023));
            end
            else
            begin
                load_entry(hole, graph_lo + $urandom_range(0, graph_span - 1));
            end
            hole = unwritten_on_face(u[NODE_W-1:0], v[NODE_W-1:0]);
        end
        issue(KIND_WALK, ENTRY_W'($urandom_range(0, 4095)), NODE_W'($urandom_range(0, 1023)),
              u[NODE_W-1:0], v[NODE_W-1:0]);
    endtask

    // n-gonal prism: outer ring from first, inner ring from first + side
    task automatic load_prism(input int side, input int first);
        int i;
        graph_lo   = first;
        graph_span = 2 * side;
        for (i = 0; i < side; i++)
        begin
            load_node(first + i, first + (i + 1) % side, first + (i + side - 1) % side,
                      first + side + i);
            load_node(first + side + i, first + side + (i + side - 1) % side,
                      first + side + (i + 1) % side, first + i);
        end
    endtask

    // wait until every traced result is back and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic write_base(input int b);
        cfg_we       <= 1'b1;
        cfg_data     <= b[ENTRY_W-1:0];
        planned_base = b[ENTRY_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin : stimulus
        int  phase;
        int  side;
        int  first;
        int  pick;
        int  r;
        int  loop_node;
        bit  phase_idle;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_base(0);

        // self loops close at once, no table reads
        walk_arc(0, 0);
        walk_arc(1023, 1023);
        // small multigraph on nodes 0, 512 and 1023
        load_node(0, 1023, 512, 1023);
        load_node(1023, 0, 0, 0);
        load_node(512, 0, 0, 1023);
        // oscillates between 0 and 1023: face too long, duplicate slot tie
        walk_arc(512, 0);
        // node 5 missing from the list of node 0
        walk_arc(5, 0);
        // closes after two nodes, smallest arc not at the start
        walk_arc(1023, 0);
        // missing after one step, then a face that closes after three nodes
        walk_arc(0, 512);
        walk_arc(1023, 512);

        // random phases: new base, new prism, walks and noise
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            wait_idle();
            phase++;
            side = $urandom_range(3, 8);
            case (phase)
                1:       write_base(4095);
                3:       write_base(1);
                default: write_base($urandom_range(0, 4095));
            endcase
            case (phase)
                1:       first = 1024 - 2 * side;
                2:       first = 0;
                default: first = $urandom_range(0, 1024 - 2 * side);
            endcase
            phase_idle = ($urandom_range(0, 3) != 0);
            load_prism(side, first);
            repeat ($urandom_range(12, 20))
            begin
                idle_enable <= phase_idle && (sent < ITEM_TARGET - CALM_TAIL);
                pick = $urandom_range(0, 19);
                r    = $urandom_range(0, 2 * side - 1);
                if (pick < 13)
                begin
                    walk_arc(first + r,
                             int'(planned_table[slot_addr(first + r,
                                                          $urandom_range(0, 2))]));
                end
                else if (pick < 15)
                begin
                    // corrupt a graph entry or scribble anywhere
                    if ($urandom_range(0, 1) == 0)
                    begin
                        load_entry(int'(slot_addr(first + r, $urandom_range(0, 2))),
                                   first + $urandom_range(0, 2 * side - 1));
                    end
                    else
                    begin
                        load_entry($urandom_range(0, 4095), $urandom_range(0, 1023));
                    end
                end
                else if (pick < 17)
                begin
                    walk_arc(first + r, first + $urandom_range(0, 2 * side - 1));
                end
                else if (pick < 18)
                begin
                    loop_node = $urandom_range(0, 1023);
                    walk_arc(loop_node, loop_node);
                end
                else
                begin
                    walk_arc($urandom_range(0, 1023), $urandom_range(0, 1023));
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- cubic_graph_face_walker.f -----
rtl/cgfw_pkg.sv
rtl/cgfw_table.sv
rtl/cgfw_slot_search.sv
rtl/cgfw_walker.sv
rtl/cubic_graph_face_walker.sv
sim/face_walk_checker.sv
sim/testbench.sv
